// ===== hw/rtl/ppfl_pkg.sv =====
`timescale 1ns / 1ps
package ppfl_pkg;
    localparam int DEF_SLOTS  = 1024;
    localparam int DEF_OWNERS = 64;
    localparam int PORT_W     = 16;
    localparam int KEY_W      = 32;
    localparam int CNT_W      = 11;

    typedef enum logic [1:0] {
        K_INIT, K_ALLOC, K_FREE_ONE, K_FREE_ALL
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK, ST_NO_SPACE, ST_NOT_FOUND, ST_BAD_OWNER, ST_BAD_PORT
    } t_status;

    typedef enum logic {
        CFG_FIRST, CFG_LAST
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_SCAN, S_DISP, S_ALLOC_RD, S_ALLOC_WR, S_WALK_RD, S_WALK_CHK,
        S_UNLINK, S_PUSH_A, S_PUSH_B, S_FALL_RD, S_FALL_CHK, S_OWR, S_DONE
    } t_state;

    typedef struct packed {
        t_kind               kind;
        logic [KEY_W-1:0]    owner_id;
        logic [PORT_W-1:0]   port;
        logic                two_ports;
        logic                to_disabled;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [PORT_W-1:0]   first_result_port;
        logic [PORT_W-1:0]   additional_port;
        logic [CNT_W-1:0]    freed_count;
        logic [CNT_W-1:0]    free_count;
        logic [CNT_W-1:0]    disabled_count;
    } t_rsp;
endpackage

// ===== hw/rtl/ppfl_req_if.sv =====
`timescale 1ns / 1ps
interface ppfl_req_if;
    import ppfl_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ppfl_rsp_if.sv =====
`timescale 1ns / 1ps
interface ppfl_rsp_if;
    import ppfl_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ppfl_ram.sv =====
`timescale 1ns / 1ps
module ppfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/ppfl_ctrl.sv =====
`timescale 1ns / 1ps
module ppfl_ctrl #(
    parameter int SLOTS  = ppfl_pkg::DEF_SLOTS,
    parameter int OWNERS = ppfl_pkg::DEF_OWNERS,
    parameter int LW     = $clog2(SLOTS + 1),
    parameter int SIW    = $clog2(SLOTS),
    parameter int OIW    = (OWNERS > 1) ? $clog2(OWNERS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ppfl_pkg::PORT_W-1:0]   i_first,
    input  logic [ppfl_pkg::PORT_W-1:0]   i_last,
    input  logic                          i_start,
    input  ppfl_pkg::t_req                i_req,
    input  logic                          i_out_free,
    output logic                          o_idle,
    output logic                          o_done,
    output ppfl_pkg::t_rsp                o_rsp,
    output logic                          o_lk_we,
    output logic [SIW-1:0]                o_lk_waddr,
    output logic [LW-1:0]                 o_lk_wdata,
    output logic [SIW-1:0]                o_lk_raddr,
    input  logic [LW-1:0]                 i_lk_rdata,
    output logic                          o_ow_we,
    output logic [OIW-1:0]                o_ow_waddr,
    output logic [ppfl_pkg::KEY_W+LW-1:0] o_ow_wdata,
    output logic [OIW-1:0]                o_ow_raddr,
    input  logic [ppfl_pkg::KEY_W+LW-1:0] i_ow_rdata
);
    import ppfl_pkg::*;

    localparam int OCW = $clog2(OWNERS + 1);

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;
    logic [KEY_W-1:0]  r_owner, n_owner;
    logic              r_two, n_two, r_dis, n_dis;
    logic [PORT_W-2:0] r_target, n_target;
    t_status           r_status, n_status;
    logic [PORT_W-1:0] r_p0, n_p0, r_p1, n_p1;
    logic [LW-1:0]     r_freed, n_freed, r_cnt, n_cnt, r_n, n_n;
    logic [OCW-1:0]    r_scan, n_scan;
    logic              r_chk_vld, n_chk_vld;
    logic [OIW-1:0]    r_chk_idx, n_chk_idx;
    logic              r_found, n_found, r_spare_ok, n_spare_ok;
    logic [OIW-1:0]    r_oidx, n_oidx, r_spare, n_spare;
    logic [LW-1:0]     r_ohead, n_ohead;
    logic              r_ovalid, n_ovalid;
    logic [LW-1:0]     r_cur, n_cur, r_prev, n_prev, r_nxt, n_nxt;
    logic              r_l, n_l;
    logic [LW-1:0]     r_head [2];
    logic [LW-1:0]     n_head [2];
    logic [LW-1:0]     r_tail [2];
    logic [LW-1:0]     n_tail [2];
    logic [LW-1:0]     r_total [2];
    logic [LW-1:0]     n_total [2];
    logic [OWNERS-1:0] r_valid, n_valid;

    logic [PORT_W-1:0] w_diff;
    logic [PORT_W-2:0] w_half;
    logic [LW-1:0]     w_init_n;
    logic              w_port_bad;
    logic              w_short;
    logic [KEY_W-1:0]  w_key;
    logic [LW-1:0]     w_key_head;
    logic [PORT_W-1:0] w_port_val;
    logic              w_hit;
    logic              w_more;

    assign w_diff     = i_last - i_first;
    assign w_half     = w_diff[PORT_W-1:1];
    assign w_init_n   = (i_last <= i_first) ? '0 :
                        (32'(w_half) > SLOTS) ? LW'(SLOTS) : LW'(w_half);
    assign w_port_bad = (i_req.port < i_first) || (i_req.port >= i_last);
    assign w_short    = ((LW+1)'(r_total[0]) + (LW+1)'(r_total[1])) <
                        (r_two ? (LW+1)'(2) : (LW+1)'(1));
    assign w_key      = i_ow_rdata[KEY_W+LW-1:LW];
    assign w_key_head = i_ow_rdata[LW-1:0];
    assign w_port_val = i_first + 16'({SIW'(r_cur - 1'b1), 1'b0});
    assign w_hit      = 16'(SIW'(r_cur - 1'b1)) == 16'(r_target);
    assign w_more     = n_ovalid && (r_cnt < LW'(SLOTS));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_req.kind == K_INIT) begin
                        n_state = (w_init_n == '0) ? S_DONE : S_INIT;
                    end else if (i_req.owner_id == '0) begin
                        n_state = S_DONE;
                    end else if (i_req.kind == K_FREE_ONE && w_port_bad) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_INIT: begin
                if (r_cnt + 1'b1 == r_n) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (r_chk_vld && r_chk_idx == OIW'(OWNERS - 1)) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (r_kind)
                    K_ALLOC:    n_state = (w_short || (!r_found && !r_spare_ok)) ?
                                          S_DONE : S_ALLOC_RD;
                    K_FREE_ONE: n_state = r_found ? S_WALK_RD : S_DONE;
                    default:    n_state = r_found ? S_FALL_RD : S_DONE;
                endcase
            end
            S_ALLOC_RD: begin
                n_state = (r_head[0] == '0 && r_head[1] == '0) ? S_OWR : S_ALLOC_WR;
            end
            S_ALLOC_WR: begin
                n_state = (r_two && r_cnt == '0) ? S_ALLOC_RD : S_OWR;
            end
            S_WALK_RD: begin
                n_state = (r_cur == '0 || r_cnt == LW'(SLOTS)) ? S_DONE : S_WALK_CHK;
            end
            S_WALK_CHK: n_state = w_hit ? S_UNLINK : S_WALK_RD;
            S_UNLINK:   n_state = S_PUSH_A;
            S_PUSH_A:   n_state = S_PUSH_B;
            S_PUSH_B: begin
                if (r_kind == K_FREE_ALL && w_more) begin
                    n_state = S_FALL_RD;
                end else begin
                    n_state = S_OWR;
                end
            end
            S_FALL_RD:  n_state = (r_ohead == '0) ? S_OWR : S_FALL_CHK;
            S_FALL_CHK: n_state = S_PUSH_A;
            S_OWR:      n_state = S_DONE;
            S_DONE:     n_state = i_out_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_kind = r_kind; n_owner = r_owner; n_two = r_two; n_dis = r_dis;
        n_target = r_target; n_status = r_status; n_p0 = r_p0; n_p1 = r_p1;
        n_freed = r_freed; n_cnt = r_cnt; n_n = r_n; n_scan = r_scan;
        n_chk_vld = 1'b0; n_chk_idx = r_chk_idx; n_found = r_found;
        n_spare_ok = r_spare_ok; n_oidx = r_oidx; n_spare = r_spare;
        n_ohead = r_ohead; n_ovalid = r_ovalid; n_cur = r_cur; n_prev = r_prev;
        n_nxt = r_nxt; n_l = r_l; n_head = r_head; n_tail = r_tail;
        n_total = r_total; n_valid = r_valid;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_kind = i_req.kind; n_owner = i_req.owner_id;
                    n_two = i_req.two_ports; n_dis = i_req.to_disabled;
                    n_target = (PORT_W-1)'((i_req.port - i_first) >> 1);
                    n_status = ST_OK; n_p0 = '0; n_p1 = '0; n_freed = '0;
                    n_cnt = '0; n_scan = '0; n_found = 1'b0; n_spare_ok = 1'b0;
                    if (i_req.kind == K_INIT) begin
                        n_n = w_init_n;
                        n_head[0] = (w_init_n == '0) ? '0 : LW'(1);
                        n_tail[0] = w_init_n; n_total[0] = w_init_n;
                        n_head[1] = '0; n_tail[1] = '0; n_total[1] = '0;
                    end else if (i_req.owner_id == '0) begin
                        n_status = ST_BAD_OWNER;
                    end else if (i_req.kind == K_FREE_ONE && w_port_bad) begin
                        n_status = ST_BAD_PORT;
                    end
                end
            end
            S_INIT: n_cnt = r_cnt + 1'b1;
            S_SCAN: begin
                if (r_scan < OCW'(OWNERS)) begin
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_scan[OIW-1:0];
                    n_scan = r_scan + 1'b1;
                end
                if (r_chk_vld) begin
                    if (!r_found && r_valid[r_chk_idx] && w_key == r_owner) begin
                        n_found = 1'b1; n_oidx = r_chk_idx; n_ohead = w_key_head;
                    end
                    if (!r_spare_ok && !r_valid[r_chk_idx]) begin
                        n_spare_ok = 1'b1; n_spare = r_chk_idx;
                    end
                end
            end
            S_DISP: begin
                n_ovalid = r_found;
                n_cur = r_ohead; n_prev = '0;
                if (r_kind == K_ALLOC) begin
                    if (w_short) begin
                        n_status = ST_NO_SPACE;
                    end else if (!r_found && !r_spare_ok) begin
                        n_status = ST_BAD_OWNER;
                    end else if (!r_found) begin
                        n_oidx = r_spare;
                    end
                end else if (!r_found) begin
                    n_status = ST_NOT_FOUND;
                end
            end
            S_ALLOC_RD: begin
                if (r_head[0] != '0) begin
                    n_l = 1'b0; n_cur = r_head[0];
                end else if (r_head[1] != '0) begin
                    n_l = 1'b1; n_cur = r_head[1];
                end else begin
                    n_status = ST_NO_SPACE;
                end
            end
            S_ALLOC_WR: begin
                n_head[r_l] = i_lk_rdata;
                if (i_lk_rdata == '0) begin
                    n_tail[r_l] = '0;
                end
                if (r_total[r_l] != '0) begin
                    n_total[r_l] = r_total[r_l] - 1'b1;
                end
                n_ovalid = 1'b1; n_ohead = r_cur;
                if (r_cnt == '0) begin
                    n_p0 = w_port_val;
                end else begin
                    n_p1 = w_port_val;
                end
                n_cnt = r_cnt + 1'b1;
            end
            S_WALK_RD: begin
                if (r_cur == '0 || r_cnt == LW'(SLOTS)) begin
                    n_status = ST_NOT_FOUND;
                end
            end
            S_WALK_CHK: begin
                n_nxt = i_lk_rdata;
                if (!w_hit) begin
                    n_prev = r_cur; n_cur = i_lk_rdata; n_cnt = r_cnt + 1'b1;
                end
            end
            S_UNLINK: begin
                if (r_prev == '0) begin
                    if (r_nxt != '0) begin
                        n_ohead = r_nxt;
                    end else begin
                        n_ovalid = 1'b0;
                    end
                end
            end
            S_PUSH_A: n_l = r_dis;
            S_PUSH_B: begin
                n_tail[r_l] = r_cur;
                if (r_head[r_l] == '0) begin
                    n_head[r_l] = r_cur;
                end
                if (r_total[r_l] < LW'(SLOTS)) begin
                    n_total[r_l] = r_total[r_l] + 1'b1;
                end
                n_freed = r_freed + 1'b1;
            end
            S_FALL_RD: begin
                n_cur = r_ohead;
                if (r_ohead == '0) begin
                    n_ovalid = 1'b0;
                end
            end
            S_FALL_CHK: begin
                if (i_lk_rdata != '0) begin
                    n_ohead = i_lk_rdata;
                end else begin
                    n_ovalid = 1'b0;
                end
                n_cnt = r_cnt + 1'b1;
            end
            S_OWR: begin
                n_valid[r_oidx] = r_ovalid;
                if (r_kind == K_FREE_ALL && r_freed == '0) begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        o_idle = 1'b0; o_done = 1'b0;
        o_lk_we = 1'b0; o_lk_waddr = SIW'(r_cur - 1'b1); o_lk_wdata = '0;
        o_lk_raddr = SIW'(r_cur - 1'b1);
        o_ow_we = 1'b0; o_ow_waddr = r_oidx; o_ow_wdata = {r_owner, r_ohead};
        o_ow_raddr = r_scan[OIW-1:0];
        case (r_state)
            S_IDLE: o_idle = 1'b1;
            S_INIT: begin
                o_lk_we = 1'b1;
                o_lk_waddr = r_cnt[SIW-1:0];
                o_lk_wdata = (r_cnt + 1'b1 == r_n) ? '0 : r_cnt + LW'(2);
            end
            S_ALLOC_RD: begin
                o_lk_raddr = (r_head[0] != '0) ? SIW'(r_head[0] - 1'b1) :
                                                 SIW'(r_head[1] - 1'b1);
            end
            S_ALLOC_WR: begin
                o_lk_we = 1'b1;
                o_lk_wdata = r_ovalid ? r_ohead : '0;
            end
            S_UNLINK: begin
                o_lk_we = (r_prev != '0);
                o_lk_waddr = SIW'(r_prev - 1'b1);
                o_lk_wdata = r_nxt;
            end
            S_PUSH_A: begin
                o_lk_we = (r_tail[r_dis] != '0);
                o_lk_waddr = SIW'(r_tail[r_dis] - 1'b1);
                o_lk_wdata = r_cur;
            end
            S_PUSH_B: o_lk_we = 1'b1;
            S_FALL_RD: o_lk_raddr = SIW'(r_ohead - 1'b1);
            S_OWR: o_ow_we = 1'b1;
            S_DONE: o_done = i_out_free;
            default: ;
        endcase
        o_rsp.status            = r_status;
        o_rsp.first_result_port = r_p0;
        o_rsp.additional_port   = r_p1;
        o_rsp.freed_count       = CNT_W'(r_freed);
        o_rsp.free_count        = CNT_W'(r_total[0]);
        o_rsp.disabled_count    = CNT_W'(r_total[1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chk_vld <= 1'b0;
            r_head <= '{default: '0};
            r_tail <= '{default: '0};
            r_total <= '{default: '0};
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_chk_vld <= n_chk_vld;
            r_head <= n_head;
            r_tail <= n_tail;
            r_total <= n_total;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind; r_owner <= n_owner; r_two <= n_two; r_dis <= n_dis;
        r_target <= n_target; r_status <= n_status; r_p0 <= n_p0; r_p1 <= n_p1;
        r_freed <= n_freed; r_cnt <= n_cnt; r_n <= n_n; r_scan <= n_scan;
        r_chk_idx <= n_chk_idx; r_found <= n_found; r_spare_ok <= n_spare_ok;
        r_oidx <= n_oidx; r_spare <= n_spare; r_ohead <= n_ohead;
        r_ovalid <= n_ovalid; r_cur <= n_cur; r_prev <= n_prev; r_nxt <= n_nxt;
        r_l <= n_l;
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == S_IDLE) else $error("start outside idle");
    a_done_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> r_state == S_IDLE) else $error("done did not return to idle");
    a_free_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head[0] == '0) == (r_tail[0] == '0)) else $error("free list head/tail mismatch");
    a_dis_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head[1] == '0) == (r_tail[1] == '0)) else $error("disabled list head/tail mismatch");
endmodule

// ===== hw/rtl/port_pair_free_list_allocator.sv =====
`timescale 1ns / 1ps
// Port pair allocator over one link memory (SLOTS entries) and one owner memory
// (OWNERS entries), one item at a time. Init writes the link chain of n slots,
// one link write per cycle. Every other valid item first scans the owner memory,
// one entry per cycle; allocate then takes one or two slots, free-one-port walks
// the owner's chain to the port and releases it, and free-all releases every
// slot of the owner, all bound by the one link memory. The result sits in an
// output register while the next item may be accepted.
module port_pair_free_list_allocator #(
    parameter int SLOTS  = ppfl_pkg::DEF_SLOTS,
    parameter int OWNERS = ppfl_pkg::DEF_OWNERS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [ppfl_pkg::PORT_W-1:0] i_cfg_data,
    ppfl_req_if.sink                    i_req,
    ppfl_rsp_if.source                  o_rsp
);
    import ppfl_pkg::*;

    localparam int LW  = $clog2(SLOTS + 1);
    localparam int SIW = $clog2(SLOTS);
    localparam int OIW = (OWNERS > 1) ? $clog2(OWNERS) : 1;

    logic [PORT_W-1:0] r_first, r_last;
    logic              r_ovalid;
    t_rsp              r_rsp;
    logic              w_idle, w_done, w_out_free;
    t_rsp              w_rsp;
    logic              w_lk_we, w_ow_we;
    logic [SIW-1:0]    w_lk_waddr, w_lk_raddr;
    logic [LW-1:0]     w_lk_wdata, w_lk_rdata;
    logic [OIW-1:0]    w_ow_waddr, w_ow_raddr;
    logic [KEY_W+LW-1:0] w_ow_wdata, w_ow_rdata;

    assign w_out_free  = !r_ovalid || o_rsp.ready;
    assign i_req.ready = w_idle;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_last <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FIRST: r_first <= i_cfg_data;
                    CFG_LAST:  r_last <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_done) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_rsp <= w_rsp;
        end
    end

    ppfl_ctrl #(.SLOTS(SLOTS), .OWNERS(OWNERS), .LW(LW), .SIW(SIW), .OIW(OIW)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_first(r_first), .i_last(r_last),
        .i_start(i_req.valid && w_idle), .i_req(i_req.data), .i_out_free(w_out_free),
        .o_idle(w_idle), .o_done(w_done), .o_rsp(w_rsp),
        .o_lk_we(w_lk_we), .o_lk_waddr(w_lk_waddr), .o_lk_wdata(w_lk_wdata),
        .o_lk_raddr(w_lk_raddr), .i_lk_rdata(w_lk_rdata),
        .o_ow_we(w_ow_we), .o_ow_waddr(w_ow_waddr), .o_ow_wdata(w_ow_wdata),
        .o_ow_raddr(w_ow_raddr), .i_ow_rdata(w_ow_rdata)
    );

    ppfl_ram #(.WIDTH(LW), .DEPTH(SLOTS), .AW(SIW)) u_link_ram (
        .i_clk(i_clk), .i_we(w_lk_we), .i_waddr(w_lk_waddr), .i_wdata(w_lk_wdata),
        .i_raddr(w_lk_raddr), .o_rdata(w_lk_rdata)
    );

    ppfl_ram #(.WIDTH(KEY_W + LW), .DEPTH(OWNERS), .AW(OIW)) u_owner_ram (
        .i_clk(i_clk), .i_we(w_ow_we), .i_waddr(w_ow_waddr), .i_wdata(w_ow_wdata),
        .i_raddr(w_ow_raddr), .o_rdata(w_ow_rdata)
    );
endmodule
